// ----- rtl/npslc_pkg.sv -----
`timescale 1ns / 1ps

package npslc_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int ENTRY_W      = 6;
    localparam int POINT_W      = 6;
    localparam int METRIC_W     = 37;
    localparam int RESULT_LIMIT = 64;
    localparam int DIM_CFG_W    = 3;
    localparam int NPTS_W       = 7;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;

    localparam logic [METRIC_W-1:0] METRIC_MAX = '1;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_EUCLID = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HARD   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NPTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_DECIDE
    } state_t;

    typedef enum logic [1:0] {
        SEL_DECISION,
        SEL_DIST,
        SEL_HARD
    } out_sel_t;

    typedef struct packed {
        logic                       command;
        logic [ENTRY_W-1:0]         entry_index;
        logic signed [SAMPLE_W-1:0] in_real;
        logic signed [SAMPLE_W-1:0] in_imag;
    } req_t;

    typedef struct packed {
        logic [POINT_W-1:0]  point_index;
        logic [METRIC_W-1:0] metric;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic               tbl_we;
        logic               smp_we;
        logic               issue;
        logic               live;
        logic               first;
        logic               fin;
        logic [POINT_W-1:0] pt;
        logic               dist_rd;
        logic               out_load;
        out_sel_t           out_sel;
        logic               out_last;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/npslc_ctrl.sv -----
`timescale 1ns / 1ps

module npslc_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_DIM     = 4,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int EW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [npslc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [npslc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                req_command,
    input  npslc_pkg::sts_t                     sts,
    output npslc_pkg::cmd_t                     cmd,
    output logic [AW-1:0]                       tbl_addr,
    output logic [EW-1:0]                       elem_idx
);

    localparam int DCW       = $clog2(MAX_DIM + 1);
    localparam int ADDR_SPAN = (TABLE_DEPTH > MAX_DIM) ? TABLE_DEPTH : MAX_DIM;
    localparam int ACW       = $clog2(ADDR_SPAN + 1);

    npslc_pkg::state_t state_reg, state_next;

    logic [npslc_pkg::DIM_CFG_W-1:0] dim_reg;
    logic [npslc_pkg::NPTS_W-1:0]    npts_reg;
    logic [npslc_pkg::MODE_W-1:0]    mode_reg;

    logic [EW-1:0]                 elem_reg, elem_next;
    logic [npslc_pkg::POINT_W-1:0] pt_reg, pt_next;
    logic [ACW-1:0]                addr_reg, addr_next;

    logic [DCW-1:0]                dim_eff;
    logic [EW-1:0]                 dim_last;
    logic [npslc_pkg::NPTS_W-1:0]  cap_tab [MAX_DIM];
    logic [npslc_pkg::NPTS_W-1:0]  npts_cap;
    logic [npslc_pkg::NPTS_W-1:0]  npts_eff;
    logic [npslc_pkg::POINT_W-1:0] pts_last;
    logic [EW-1:0]                 smp_idx;
    logic                          multi_out;
    logic                          elem_fin;

    // Point-count ceiling for each dimensionality, settled at elaboration
    for (genvar k = 0; k < MAX_DIM; k++) begin : g_cap
        localparam int Quot = TABLE_DEPTH / (k + 1);
        localparam int Cap  = (Quot > npslc_pkg::RESULT_LIMIT) ? npslc_pkg::RESULT_LIMIT :
                              ((Quot < 1) ? 1 : Quot);
        assign cap_tab[k] = npslc_pkg::NPTS_W'(Cap);
    end

    always_comb
    begin
        if (dim_reg == '0)
        begin
            dim_eff = DCW'(1);
        end
        else if (int'(dim_reg) > MAX_DIM)
        begin
            dim_eff = DCW'(MAX_DIM);
        end
        else
        begin
            dim_eff = DCW'(dim_reg);
        end
    end

    assign dim_last = EW'(dim_eff - DCW'(1));
    assign npts_cap = cap_tab[dim_last];

    always_comb
    begin
        if (npts_reg == '0)
        begin
            npts_eff = npslc_pkg::NPTS_W'(1);
        end
        else if (npts_reg > npts_cap)
        begin
            npts_eff = npts_cap;
        end
        else
        begin
            npts_eff = npts_reg;
        end
    end

    assign pts_last  = npslc_pkg::POINT_W'(npts_eff - npslc_pkg::NPTS_W'(1));
    // Restart the symbol when dimensionality dropped below the count
    assign smp_idx   = (int'(elem_reg) >= int'(dim_eff)) ? '0 : elem_reg;
    assign multi_out = mode_reg inside {npslc_pkg::MODE_EUCLID, npslc_pkg::MODE_HARD};
    assign elem_fin  = (elem_reg == dim_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg  <= npslc_pkg::DIM_CFG_W'(1);
            npts_reg <= npslc_pkg::NPTS_W'(2);
            mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                npslc_pkg::CFG_DIM:  dim_reg  <= cfg_data[npslc_pkg::DIM_CFG_W-1:0];
                npslc_pkg::CFG_NPTS: npts_reg <= cfg_data[npslc_pkg::NPTS_W-1:0];
                npslc_pkg::CFG_MODE: mode_reg <= cfg_data[npslc_pkg::MODE_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= npslc_pkg::ST_IDLE;
            elem_reg  <= '0;
            pt_reg    <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
            pt_reg    <= pt_next;
            addr_reg  <= addr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        pt_next    = pt_reg;
        addr_next  = addr_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        elem_idx   = elem_reg;
        tbl_addr   = AW'(addr_reg);

        case (state_reg)
            npslc_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                elem_idx  = smp_idx;
                if (req_valid)
                begin
                    case (req_command)
                        npslc_pkg::CMD_LOAD:
                        begin
                            cmd.tbl_we = 1'b1;
                        end
                        npslc_pkg::CMD_SAMPLE:
                        begin
                            cmd.smp_we = 1'b1;
                            if (smp_idx == dim_last)
                            begin
                                elem_next  = '0;
                                pt_next    = '0;
                                addr_next  = '0;
                                state_next = npslc_pkg::ST_SEARCH;
                            end
                            else
                            begin
                                elem_next = smp_idx + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            npslc_pkg::ST_SEARCH:
            begin
                // One table entry per cycle, points in order
                cmd.issue = 1'b1;
                cmd.live  = (int'(addr_reg) < TABLE_DEPTH);
                cmd.first = (elem_reg == '0);
                cmd.fin   = elem_fin;
                cmd.pt    = pt_reg;
                addr_next = addr_reg + 1'b1;
                if (elem_fin)
                begin
                    elem_next = '0;
                    if (pt_reg == pts_last)
                    begin
                        state_next = npslc_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        pt_next = pt_reg + 1'b1;
                    end
                end
                else
                begin
                    elem_next = elem_reg + 1'b1;
                end
            end

            npslc_pkg::ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    pt_next    = '0;
                    state_next = multi_out ? npslc_pkg::ST_EMIT_RD : npslc_pkg::ST_DECIDE;
                end
            end

            npslc_pkg::ST_EMIT_RD:
            begin
                cmd.dist_rd = 1'b1;
                cmd.pt      = pt_reg;
                state_next  = npslc_pkg::ST_EMIT_LD;
            end

            npslc_pkg::ST_EMIT_LD:
            begin
                cmd.pt = pt_reg;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = (mode_reg == npslc_pkg::MODE_EUCLID) ?
                                   npslc_pkg::SEL_DIST : npslc_pkg::SEL_HARD;
                    cmd.out_last = (pt_reg == pts_last);
                    if (pt_reg == pts_last)
                    begin
                        state_next = npslc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pt_next    = pt_reg + 1'b1;
                        state_next = npslc_pkg::ST_EMIT_RD;
                    end
                end
            end

            npslc_pkg::ST_DECIDE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = npslc_pkg::SEL_DECISION;
                    cmd.out_last = 1'b1;
                    state_next   = npslc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = npslc_pkg::ST_IDLE;
            end
        endcase
    end

    a_elem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(elem_reg) < MAX_DIM)
        else $error("element counter past the sample buffer");

    a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == npslc_pkg::ST_DRAIN && !sts.pipe_busy) |=> !sts.pipe_busy)
        else $error("distance pipeline refilled after the search finished");

endmodule

// ----- rtl/npslc_dp.sv -----
`timescale 1ns / 1ps

module npslc_dp #(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_DIM     = 4,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int EW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  npslc_pkg::req_t   req,
    input  npslc_pkg::cmd_t   cmd,
    input  logic [AW-1:0]     tbl_addr,
    input  logic [EW-1:0]     elem_idx,
    output npslc_pkg::sts_t   sts,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output npslc_pkg::rsp_t   rsp
);

    localparam int SW  = npslc_pkg::SAMPLE_W;
    localparam int DW  = SW + 1;
    localparam int SQW = 2 * DW - 1;
    localparam int TW  = 2 * DW;
    localparam int MW  = npslc_pkg::METRIC_W;
    localparam int PW  = npslc_pkg::POINT_W;

    logic [2*SW-1:0] tbl_mem [TABLE_DEPTH];
    logic [2*SW-1:0] smp_mem [MAX_DIM];
    logic [MW-1:0]   dist_mem [npslc_pkg::RESULT_LIMIT];

    logic [2*SW-1:0] tbl_rd_reg, smp_rd_reg;
    logic [MW-1:0]   dist_rd_reg;

    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic            first1_reg, first2_reg, first3_reg;
    logic            fin1_reg, fin2_reg, fin3_reg, fin4_reg;
    logic [PW-1:0]   pt1_reg, pt2_reg, pt3_reg, pt4_reg;
    logic            live1_reg;

    logic signed [DW-1:0]   diff_re, diff_im;
    logic signed [2*DW-1:0] prod_re, prod_im;
    logic [SQW-1:0]         sq_re_reg, sq_im_reg;
    logic [TW-1:0]          term_reg;
    logic [MW-1:0]          acc_base;
    logic [MW:0]            acc_sum;
    logic [MW-1:0]          acc_reg;

    logic [MW-1:0]   best_reg;
    logic [PW-1:0]   win_reg;
    logic            point_done;

    logic            rsp_valid_reg;
    npslc_pkg::rsp_t rsp_reg;
    logic [PW-1:0]   point_sel;
    logic [MW-1:0]   metric_sel;
    logic            load_in_range;

    assign load_in_range = (int'(req.entry_index) < TABLE_DEPTH);
    assign point_done    = v4_reg && fin4_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.tbl_we && load_in_range)
        begin
            tbl_mem[AW'(req.entry_index)] <= {req.in_real, req.in_imag};
        end
        if (cmd.issue)
        begin
            tbl_rd_reg <= tbl_mem[tbl_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.smp_we)
        begin
            smp_mem[elem_idx] <= {req.in_real, req.in_imag};
        end
        if (cmd.issue)
        begin
            smp_rd_reg <= smp_mem[elem_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (point_done)
        begin
            dist_mem[pt4_reg] <= acc_reg;
        end
        if (cmd.dist_rd)
        begin
            dist_rd_reg <= dist_mem[cmd.pt];
        end
    end

    assign diff_re = $signed({smp_rd_reg[2*SW-1], smp_rd_reg[2*SW-1:SW]})
                   - $signed({tbl_rd_reg[2*SW-1], tbl_rd_reg[2*SW-1:SW]});
    assign diff_im = $signed({smp_rd_reg[SW-1], smp_rd_reg[SW-1:0]})
                   - $signed({tbl_rd_reg[SW-1], tbl_rd_reg[SW-1:0]});
    assign prod_re = diff_re * diff_re;
    assign prod_im = diff_im * diff_im;

    assign acc_base = first3_reg ? '0 : acc_reg;
    assign acc_sum  = {1'b0, acc_base} + (MW + 1)'(term_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        first1_reg <= cmd.first;
        fin1_reg   <= cmd.fin;
        pt1_reg    <= cmd.pt;
        live1_reg  <= cmd.live;

        // Entries past the end of a short table add nothing
        sq_re_reg  <= live1_reg ? prod_re[SQW-1:0] : '0;
        sq_im_reg  <= live1_reg ? prod_im[SQW-1:0] : '0;
        first2_reg <= first1_reg;
        fin2_reg   <= fin1_reg;
        pt2_reg    <= pt1_reg;

        term_reg   <= TW'(sq_re_reg) + TW'(sq_im_reg);
        first3_reg <= first2_reg;
        fin3_reg   <= fin2_reg;
        pt3_reg    <= pt2_reg;

        if (v3_reg)
        begin
            acc_reg <= acc_sum[MW] ? npslc_pkg::METRIC_MAX : acc_sum[MW-1:0];
        end
        fin4_reg <= fin3_reg;
        pt4_reg  <= pt3_reg;

        // Strict less-than keeps the lowest index on a tie
        if (point_done && (pt4_reg == '0 || acc_reg < best_reg))
        begin
            best_reg <= acc_reg;
            win_reg  <= pt4_reg;
        end

        if (cmd.out_load)
        begin
            rsp_reg.point_index <= point_sel;
            rsp_reg.metric      <= metric_sel;
            rsp_reg.last        <= cmd.out_last;
        end
    end

    always_comb
    begin
        case (cmd.out_sel)
            npslc_pkg::SEL_DECISION:
            begin
                point_sel  = win_reg;
                metric_sel = best_reg;
            end
            npslc_pkg::SEL_DIST:
            begin
                point_sel  = cmd.pt;
                metric_sel = dist_rd_reg;
            end
            npslc_pkg::SEL_HARD:
            begin
                point_sel  = cmd.pt;
                metric_sel = (cmd.pt == win_reg) ? '0 : MW'(1);
            end
            default:
            begin
                point_sel  = win_reg;
                metric_sel = best_reg;
            end
        endcase
    end

    assign sts.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign sts.out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid     = rsp_valid_reg;
    assign rsp           = rsp_reg;

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tbl_we |-> !sts.pipe_busy)
        else $error("table written while a search is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("pending result overwritten");

    a_dist_order: assert property (@(posedge clk) disable iff (!rst_n)
        point_done |-> !cmd.dist_rd)
        else $error("distance read before the search finished");

endmodule

// ----- rtl/nearest_point_slicer_top.sv -----
`timescale 1ns / 1ps

// Nearest-point slicer: minimum Euclidean distance demapper over a loaded table.
// Request channel (req_valid/req_ready/req_data): a load item writes one table
// entry; a sample item delivers one complex element. Items are taken only while
// the block is idle. When the element that completes a symbol is taken, the
// block scans npts*dim table entries at one entry per cycle (one table memory
// read port feeding a squaring and accumulate pipeline), then waits for the
// pipeline to empty.
// Decision mode gives one result; Euclidean and hard-symbol modes give npts
// results, one read of the distance memory each.
// Response channel (rsp_valid/rsp_ready/rsp_data) has an output register: a
// stalled receiver holds the result and pauses the emit sequence; after the
// last result is loaded the block takes new items while it still waits.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once and
// belong between symbols. Reset restores dimensionality 1, two points and
// decision mode and clears the partial symbol; table contents stay unknown
// until loaded, so load every entry that a search will read.

module nearest_point_slicer_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_DIM     = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [npslc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [npslc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  npslc_pkg::req_t                   req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output npslc_pkg::rsp_t                   rsp_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    npslc_pkg::cmd_t cmd;
    npslc_pkg::sts_t sts;
    logic [AW-1:0]   tbl_addr;
    logic [EW-1:0]   elem_idx;

    npslc_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_DIM     (MAX_DIM)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_command (req_data.command),
        .sts         (sts),
        .cmd         (cmd),
        .tbl_addr    (tbl_addr),
        .elem_idx    (elem_idx)
    );

    npslc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_DIM     (MAX_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_data),
        .cmd       (cmd),
        .tbl_addr  (tbl_addr),
        .elem_idx  (elem_idx),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_data)
    );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import npslc_pkg::*;

    localparam int TBL_DEPTH     = 64;
    localparam int MAX_DIM       = 4;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 200;
    localparam int CALM_ITEMS    = 50;

    localparam logic [MODE_W-1:0] MODE_DECISION = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;

    class slicer_scoreboard;
        logic signed [SAMPLE_W-1:0] tbl_re [TBL_DEPTH];
        logic signed [SAMPLE_W-1:0] tbl_im [TBL_DEPTH];
        logic signed [SAMPLE_W-1:0] sym_re [MAX_DIM];
        logic signed [SAMPLE_W-1:0] sym_im [MAX_DIM];
        logic [DIM_CFG_W-1:0] dim_reg  = 3'd1;
        logic [NPTS_W-1:0]    npts_reg = 7'd2;
        logic [MODE_W-1:0]    mode_reg = MODE_DECISION;
        int unsigned elem_cnt   = 0;
        int unsigned fail_count = 0;
        rsp_t due_results [$];

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DIM:  dim_reg  = val[DIM_CFG_W-1:0];
                CFG_NPTS: npts_reg = val[NPTS_W-1:0];
                CFG_MODE: mode_reg = val[MODE_W-1:0];
                default:  ;
            endcase
        endfunction

        function int unsigned waiting();
            return due_results.size();
        endfunction

        // Update the table or the symbol; search all points once a symbol is complete.
        function void note_item(req_t item);
            int unsigned dim;
            int unsigned cap;
            int unsigned npts;
            int unsigned win;
            int unsigned idx;
            longint acc;
            longint dr;
            longint di;
            logic [METRIC_W-1:0] pt_dist [RESULT_LIMIT];
            rsp_t r;
            if (item.command == CMD_LOAD)
            begin
                tbl_re[item.entry_index] = item.in_real;
                tbl_im[item.entry_index] = item.in_imag;
                return;
            end
            dim = dim_reg;
            if (dim < 1)
                dim = 1;
            if (dim > MAX_DIM)
                dim = MAX_DIM;
            // restart the symbol if the dimensionality shrank under it
            if (elem_cnt >= dim)
                elem_cnt = 0;
            sym_re[elem_cnt] = item.in_real;
            sym_im[elem_cnt] = item.in_imag;
            elem_cnt++;
            if (elem_cnt < dim)
                return;
            elem_cnt = 0;
            cap = TBL_DEPTH / dim;
            if (cap > RESULT_LIMIT)
                cap = RESULT_LIMIT;
            if (cap < 1)
                cap = 1;
            npts = npts_reg;
            if (npts < 1)
                npts = 1;
            if (npts > cap)
                npts = cap;
            win = 0;
            for (int unsigned p = 0; p < npts; p++)
            begin
                acc = 0;
                for (int unsigned e = 0; e < dim; e++)
                begin
                    idx = p * dim + e;
                    if (idx < TBL_DEPTH)
                    begin
                        dr = longint'(sym_re[e]) - longint'(tbl_re[idx]);
                        di = longint'(sym_im[e]) - longint'(tbl_im[idx]);
                        acc += dr * dr + di * di;
                    end
                end
                pt_dist[p] = (acc > longint'(METRIC_MAX)) ? METRIC_MAX : METRIC_W'(acc);
                // strict compare keeps the lowest index on a tie
                if (p == 0 || pt_dist[p] < pt_dist[win])
                    win = p;
            end
            if (mode_reg == MODE_EUCLID || mode_reg == MODE_HARD)
            begin
                for (int unsigned p = 0; p < npts; p++)
                begin
                    r.point_index = POINT_W'(p);
                    if (mode_reg == MODE_EUCLID)
                        r.metric = pt_dist[p];
                    else
                        r.metric = (p == win) ? METRIC_W'(0) : METRIC_W'(1);
                    r.last = (p + 1 == npts);
                    due_results = {due_results, r};
                end
            end
            else
            begin
                r.point_index = POINT_W'(win);
                r.metric      = pt_dist[win];
                r.last        = 1'b1;
                due_results = {due_results, r};
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (due_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result with nothing outstanding: point %0d metric %0d last %0d",
                             got.point_index, got.metric, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got.point_index !== want.point_index || got.metric !== want.metric ||
                got.last !== want.last)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("expected pt %0d metric %0d last %0d, got pt %0d metric %0d last %0d",
                             want.point_index, want.metric, want.last,
                             got.point_index, got.metric, got.last);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req_data;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp_data;

    bit calm = 1'b0;
    slicer_scoreboard sb = new();

    nearest_point_slicer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always #1 clk = ~clk;

    function automatic req_t form_req(logic cmd, logic [ENTRY_W-1:0] idx,
                                      logic signed [SAMPLE_W-1:0] re,
                                      logic signed [SAMPLE_W-1:0] im);
        req_t item;
        item.command     = cmd;
        item.entry_index = idx;
        item.in_real     = re;
        item.in_imag     = im;
        return item;
    endfunction

    // Mostly land near a table value, sometimes anywhere, sometimes at full scale.
    function automatic logic signed [SAMPLE_W-1:0] near_value(logic signed [SAMPLE_W-1:0] base);
        case ($urandom_range(0, 9))
            0:       return SAMPLE_W'($urandom());
            1:       return ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
            default: return SAMPLE_W'(base + $urandom_range(0, 600) - 300);
        endcase
    endfunction

    task automatic push_item(input req_t item);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_item(item);
    endtask

    // Hold off the sender until every result is back and the search has drained.
    task automatic settle();
        req_valid <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_registers(input logic [DIM_CFG_W-1:0] dim_val,
                                 input logic [NPTS_W-1:0] npts_val,
                                 input logic [MODE_W-1:0] mode_val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DIM;
        cfg_data  <= CFG_DATA_W'(dim_val);
        @(posedge clk);
        sb.write_reg(CFG_DIM, CFG_DATA_W'(dim_val));
        cfg_index <= CFG_NPTS;
        cfg_data  <= CFG_DATA_W'(npts_val);
        @(posedge clk);
        sb.write_reg(CFG_NPTS, CFG_DATA_W'(npts_val));
        cfg_index <= CFG_MODE;
        cfg_data  <= CFG_DATA_W'(mode_val);
        @(posedge clk);
        sb.write_reg(CFG_MODE, CFG_DATA_W'(mode_val));
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
    end

    initial
    begin
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_DIM;
        cfg_data  <= '0;
        req_valid <= 1'b0;
        req_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table so that no search reads an unwritten entry
        push_item(form_req(CMD_LOAD, 6'd0, 16'sh8000, 16'sh7fff));
        push_item(form_req(CMD_LOAD, 6'd1, 16'sh7fff, 16'sh8000));
        for (int i = 2; i < TBL_DEPTH; i++)
            push_item(form_req(CMD_LOAD, ENTRY_W'(i), SAMPLE_W'($urandom()),
                               SAMPLE_W'($urandom())));

        // registers as left by reset: one element, two points, decision
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sd0, 16'sd0));
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sh8000, 16'sh8000));
        push_item(form_req(CMD_SAMPLE, 6'd63, 16'sh7fff, 16'sh7fff));

        // two equal points: the lower index must win
        push_item(form_req(CMD_LOAD, 6'd2, 16'sd1000, -16'sd1000));
        push_item(form_req(CMD_LOAD, 6'd3, 16'sd1000, -16'sd1000));
        set_registers(3'd1, 7'd4, MODE_DECISION);
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sd1000, -16'sd1000));
        set_registers(3'd1, 7'd4, MODE_HARD);
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sd1000, -16'sd1000));

        // point count far past the table saturates
        set_registers(3'd1, 7'd127, MODE_EUCLID);
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sh7fff, 16'sh8000));

        // zero dimensionality and zero points act as one
        set_registers(3'd0, 7'd0, MODE_HARD);
        push_item(form_req(CMD_SAMPLE, 6'd0, -16'sd5, 16'sd7));

        // oversized dimensionality clamps to four, unused mode decides
        set_registers(3'd7, 7'd127, MODE_SPARE);
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sh8000, 16'sh7fff));
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sh7fff, 16'sh8000));
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sd0, 16'sd0));
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sd1000, -16'sd1000));

        // shrink dimensionality under a partial symbol
        set_registers(3'd3, 7'd3, MODE_EUCLID);
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sd100, 16'sd200));
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sd300, 16'sd400));
        set_registers(3'd2, 7'd3, MODE_EUCLID);
        push_item(form_req(CMD_SAMPLE, 6'd0, -16'sd100, -16'sd200));
        push_item(form_req(CMD_SAMPLE, 6'd0, -16'sd300, -16'sd400));

        // a table write between the elements of one symbol
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sd50, -16'sd50));
        push_item(form_req(CMD_LOAD, 6'd1, 16'sd60, -16'sd60));
        push_item(form_req(CMD_SAMPLE, 6'd0, 16'sd60, -16'sd60));

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent + CALM_ITEMS >= RANDOM_ITEMS)
                calm = 1'b1;
            set_registers(DIM_CFG_W'($urandom_range(0, 7)),
                          ($urandom_range(0, 7) == 0) ? NPTS_W'($urandom_range(0, 127))
                                                      : NPTS_W'($urandom_range(1, 6)),
                          MODE_W'($urandom_range(0, 3)));
            burst = $urandom_range(8, 30);
            repeat (burst)
            begin
                pick = $urandom_range(0, TBL_DEPTH - 1);
                if ($urandom_range(0, 4) == 0)
                begin
                    // half the loads copy another entry to provoke ties
                    if ($urandom_range(0, 1) == 0)
                        push_item(form_req(CMD_LOAD, ENTRY_W'($urandom()),
                                           sb.tbl_re[pick], sb.tbl_im[pick]));
                    else
                        push_item(form_req(CMD_LOAD, ENTRY_W'($urandom()),
                                           SAMPLE_W'($urandom()), SAMPLE_W'($urandom())));
                end
                else
                begin
                    push_item(form_req(CMD_SAMPLE, ENTRY_W'($urandom()),
                                       near_value(sb.tbl_re[pick]),
                                       near_value(sb.tbl_im[pick])));
                end
                sent++;
            end
        end

        settle();
        if (sb.fail_count == 0 && sb.waiting() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
